// File: hw/rtl/sync_framed_crc8_receiver_assert.svh
// Assertion macros shared by the receiver RTL.
// SCFR_ASSERT is qualified by reset; SCFR_ASSERT_ALWAYS is checked in reset too.
`ifndef SYNC_FRAMED_CRC8_RECEIVER_ASSERT_SVH
`define SYNC_FRAMED_CRC8_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
`define SCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SCFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SCFR_ASSERT(lbl, prop, msg)
`define SCFR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/scfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scfr_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 4;
  localparam int CFG_W  = 32;

  localparam int SYNC_BYTES_DEF = 4;
  localparam int DATA_BYTES_DEF = 14;

  // Reflected CRC-8, Dallas/Maxim polynomial
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] msg_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last_byte;
    logic              crc_ok;
  } scfr_res_t;

  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/scfr_framer.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sync_framed_crc8_receiver_assert.svh"

module scfr_framer #(
  parameter int SYNC_BYTES = scfr_pkg::SYNC_BYTES_DEF,
  parameter int DATA_BYTES = scfr_pkg::DATA_BYTES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        acc_i,
  input  wire logic [scfr_pkg::BYTE_W-1:0] rx_byte_i,
  input  wire logic [scfr_pkg::CFG_W-1:0]  pattern_i,
  output scfr_pkg::scfr_res_t              res_o
);
  import scfr_pkg::*;

  localparam int WIN_W   = BYTE_W * SYNC_BYTES;
  localparam int MSG_LEN = DATA_BYTES + 2;
  localparam int CNT_W   = $clog2(MSG_LEN);

  logic [WIN_W-1:0]  win_q, win_d, win_shift;
  logic              in_msg_q, in_msg_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] crc_q, crc_d;
  logic              is_last;
  logic [IDX_W+CNT_W-1:0] idx_ext;

  // newest byte enters at the top, oldest sits in the low byte
  if (SYNC_BYTES == 1) begin : g_win1
    assign win_shift = rx_byte_i;
  end else begin : g_winn
    assign win_shift = {rx_byte_i, win_q[WIN_W-1:BYTE_W]};
  end

  assign is_last = (cnt_q == CNT_W'(MSG_LEN - 1));
  assign idx_ext = {{IDX_W{1'b0}}, cnt_q};

  always_comb begin
    win_d    = win_q;
    in_msg_d = in_msg_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;

    res_o.valid      = acc_i & in_msg_q;
    res_o.msg_byte   = rx_byte_i;
    res_o.byte_index = idx_ext[IDX_W-1:0];
    res_o.last_byte  = is_last;
    res_o.crc_ok     = is_last && (rx_byte_i == crc_q);

    if (acc_i) begin
      if (!in_msg_q) begin
        win_d = win_shift;
        if (win_shift == pattern_i[WIN_W-1:0]) begin
          in_msg_d = 1'b1;
          cnt_d    = '0;
          crc_d    = '0;
          win_d    = '0;
        end
      end else if (is_last) begin
        in_msg_d = 1'b0;
        cnt_d    = '0;
        crc_d    = '0;
        win_d    = '0;
      end else begin
        crc_d = crc8_update(crc_q, rx_byte_i);
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      in_msg_q <= 1'b0;
      cnt_q    <= '0;
      crc_q    <= '0;
    end else begin
      win_q    <= win_d;
      in_msg_q <= in_msg_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
    end
  end

  `SCFR_ASSERT_ALWAYS(a_hunt_clean, !in_msg_q |-> (cnt_q == '0 && crc_q == '0), "hunt state dirty")
  `SCFR_ASSERT(a_msg_win_clear, in_msg_q |-> (win_q == '0), "window not cleared in message")
  `SCFR_ASSERT(a_last_ends, (acc_i && in_msg_q && is_last) |=> !in_msg_q, "message did not end")

endmodule

`default_nettype wire

// File: hw/rtl/sync_framed_crc8_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sync_framed_crc8_receiver_assert.svh"

// Sync-word framer with CRC-8 check. Bytes arrive on the rx channel one per request.
// While hunting, the last SYNC_BYTES bytes (oldest in the low byte) are compared with
// the low SYNC_BYTES bytes of sync_pattern; hunting bytes, including the one that
// completes the pattern, produce no output. The following DATA_BYTES+2 bytes are the
// message (command, data, CRC) and each is sent out with its index (low 4 bits of the
// position). The CRC byte carries last_byte=1 and crc_ok, the result of comparing it
// with a reflected CRC-8 (poly 0x8C, init 0) over the preceding message bytes. The
// window starts at zero after reset and after each sync or message end, so a pattern
// with zero low bytes may match early. Throughput is one byte per clock unless stalled:
// the window compare and a single-byte CRC update sit between the state registers, and
// one result register follows. A message byte is output in the cycle after acceptance.
// The input stalls only while the result register is full and the output is stalled.
// No clearing pass after reset. sync_pattern is written through cfg (always ready) and
// should change only while the block is idle; a change takes effect on the next hunt.
module sync_framed_crc8_receiver #(
  parameter int SYNC_BYTES = scfr_pkg::SYNC_BYTES_DEF,
  parameter int DATA_BYTES = scfr_pkg::DATA_BYTES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write
  input  wire logic                        cfg_valid_i,
  output      logic                        cfg_ready_o,
  input  wire logic [scfr_pkg::CFG_W-1:0]  cfg_sync_pattern_i,
  // received bytes
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [scfr_pkg::BYTE_W-1:0] rx_byte_i,
  // message bytes
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [scfr_pkg::BYTE_W-1:0] msg_byte_o,
  output      logic [scfr_pkg::IDX_W-1:0]  byte_index_o,
  output      logic                        last_byte_o,
  output      logic                        crc_ok_o
);
  import scfr_pkg::*;

  logic [CFG_W-1:0]  pattern_q;
  logic              in_acc;
  scfr_res_t         res;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] msg_byte_q;
  logic [IDX_W-1:0]  byte_index_q;
  logic              last_byte_q;
  logic              crc_ok_q;

  assign cfg_ready_o = 1'b1;

  // Result register can take a new byte unless it holds one that is stalled.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pattern_q <= cfg_sync_pattern_i;
    end
  end

  scfr_framer #(
    .SYNC_BYTES (SYNC_BYTES),
    .DATA_BYTES (DATA_BYTES)
  ) u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (in_acc),
    .rx_byte_i (rx_byte_i),
    .pattern_i (pattern_q),
    .res_o     (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = res.valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload loads only with a fresh result
  always_ff @(posedge clk_i) begin
    if (in_acc && res.valid) begin
      msg_byte_q   <= res.msg_byte;
      byte_index_q <= res.byte_index;
      last_byte_q  <= res.last_byte;
      crc_ok_q     <= res.crc_ok;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign msg_byte_o   = msg_byte_q;
  assign byte_index_o = byte_index_q;
  assign last_byte_o  = last_byte_q;
  assign crc_ok_o     = crc_ok_q;

  `SCFR_ASSERT(a_stall_needs_full, in_stall_o |-> out_valid_o, "input stalled while empty")
  `SCFR_ASSERT(a_drain, (out_valid_o && !out_stall_i && !in_acc) |=> !out_valid_o, "result repeated")
  `SCFR_ASSERT(a_rise_from_acc, $rose(out_valid_o) |-> $past(in_acc), "result without request")

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int SYNC_N = scfr_pkg::SYNC_BYTES_DEF;
  localparam int DATA_N = scfr_pkg::DATA_BYTES_DEF;
  localparam int MSG_N  = DATA_N + 2;  // command, data bytes, CRC byte

  localparam logic [31:0] WIN_MASK = 32'((64'd1 << (8 * SYNC_N)) - 64'd1);

  localparam int ITEM_TARGET    = 400;
  localparam int HOLD_CYCLES    = 120;   // long receiver hold-off
  localparam int HOLD_AFTER     = 40;    // message bytes seen before the hold-off
  localparam int IDLE_PCT       = 6;
  localparam int DRAIN_CYCLES   = 8;     // idle margin after both queues are empty
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request accepted

  typedef struct packed {
    logic [scfr_pkg::BYTE_W-1:0] data;
    logic [scfr_pkg::IDX_W-1:0]  index;
    logic                        last;
    logic                        crc_ok;
  } msg_beat_t;

  // ---------------------------------------------------------------------------
  // Clock, DUT signals
  // ---------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic                          cfg_valid   = 1'b0;
  logic [scfr_pkg::CFG_W-1:0]    cfg_pattern = '0;
  logic                          cfg_ready;
  logic                          in_valid    = 1'b0;
  logic [scfr_pkg::BYTE_W-1:0]   rx_byte     = '0;
  logic                          in_stall;
  logic                          out_valid;
  logic                          out_stall   = 1'b0;
  logic [scfr_pkg::BYTE_W-1:0]   msg_byte;
  logic [scfr_pkg::IDX_W-1:0]    byte_index;
  logic                          last_byte;
  logic                          crc_ok;

  sync_framed_crc8_receiver u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_sync_pattern_i(cfg_pattern),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .rx_byte_i         (rx_byte),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .msg_byte_o        (msg_byte),
    .byte_index_o      (byte_index),
    .last_byte_o       (last_byte),
    .crc_ok_o          (crc_ok)
  );

  // ---------------------------------------------------------------------------
  // Frame predictor: own copy of the pattern, hunt window and message state
  // ---------------------------------------------------------------------------
  logic [31:0]  hunt_pattern = '0;
  logic [31:0]  hunt_window  = '0;
  bit           in_frame     = 1'b0;
  int unsigned  frame_pos    = 0;
  logic [7:0]   crc_acc      = '0;

  msg_beat_t    msg_beats_due[$];  // message bytes still to come out
  logic [7:0]   rx_stream[$];      // bytes not yet accepted by the block

  int  mismatches    = 0;
  int  beats_checked = 0;
  int  fed           = 0;
  bit  calm          = 1'b0;       // no idling on either side while set

  // Reflected CRC-8, one byte, LSB first.
  function automatic logic [7:0] maxim_crc_byte(input logic [7:0] acc,
                                                input logic [7:0] d);
    logic [7:0] r;
    r = acc ^ d;
    repeat (8) r = r[0] ? ((r >> 1) ^ scfr_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic void frame_hunt_step(input logic [7:0] b);
    msg_beat_t beat;
    if (!in_frame) begin
      // newest byte enters at the top, oldest sits in the low byte
      hunt_window = ((hunt_window >> 8) | ({24'd0, b} << (8 * (SYNC_N - 1)))) & WIN_MASK;
      if (hunt_window == (hunt_pattern & WIN_MASK)) begin
        // the byte that completes the sync gives no message byte
        in_frame    = 1'b1;
        frame_pos   = 0;
        crc_acc     = '0;
        hunt_window = '0;
      end
    end else begin
      beat.data  = b;
      beat.index = frame_pos[3:0];  // wraps for long messages
      if (frame_pos + 1 >= MSG_N) begin
        beat.last   = 1'b1;
        beat.crc_ok = (b == crc_acc);
        in_frame    = 1'b0;
        frame_pos   = 0;
        crc_acc     = '0;
        hunt_window = '0;
      end else begin
        beat.last   = 1'b0;
        beat.crc_ok = 1'b0;
        crc_acc     = maxim_crc_byte(crc_acc, b);
        frame_pos++;
      end
      msg_beats_due.push_back(beat);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // rx driver: acceptance is sampled at the rising edge, the predictor and the
  // next offer run at the falling edge, so neither races the monitor.
  // ---------------------------------------------------------------------------
  logic rx_fire = 1'b0;

  always @(posedge clk_i) begin
    rx_fire <= rst_ni && in_valid && !in_stall;
  end

  always @(negedge clk_i) begin
    if (rx_fire) begin
      frame_hunt_step(rx_byte);
      void'(rx_stream.pop_front());
    end
    // an offered byte stays put until accepted
    if (!in_valid || rx_fire) begin
      if (rx_stream.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        rx_byte  <= rx_stream[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stall: random idling plus one long hold-off while rx keeps coming,
  // so the result register fills and the block stalls its input.
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && beats_checked >= HOLD_AFTER && rx_stream.size() > 8) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each accepted message byte against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    msg_beat_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (msg_beats_due.size() == 0) begin
        $error("msg_byte: expected none, actual %0h", msg_byte);
        mismatches++;
      end else begin
        want = msg_beats_due.pop_front();
        beats_checked++;
        if (msg_byte !== want.data) begin
          $error("msg_byte: expected %0h, actual %0h", want.data, msg_byte);
          mismatches++;
        end
        if (byte_index !== want.index) begin
          $error("byte_index: expected %0d, actual %0d", want.index, byte_index);
          mismatches++;
        end
        if (last_byte !== want.last) begin
          $error("last_byte: expected %0b, actual %0b", want.last, last_byte);
          mismatches++;
        end
        if (crc_ok !== want.crc_ok) begin
          $error("crc_ok: expected %0b, actual %0b", want.crc_ok, crc_ok);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long with no request accepted on any channel; an output
  // request that nothing waits for does not count as progress
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) ||
        (out_valid && !out_stall && msg_beats_due.size() != 0) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void feed(input logic [7:0] b);
    rx_stream.push_back(b);
    fed++;
  endfunction

  // first n sync bytes, lowest byte of the pattern first
  function automatic void feed_sync(input logic [31:0] pat, input int n);
    for (int k = 0; k < n; k++) feed(pat[8*k +: 8]);
  endfunction

  // sync, then the first 'keep' message bytes of a random message
  function automatic void feed_frame(input logic [31:0] pat, input bit good_crc,
                                     input int keep);
    logic [7:0] acc;
    logic [7:0] b;
    acc = '0;
    feed_sync(pat, SYNC_N);
    for (int i = 0; i < keep; i++) begin
      if (i == MSG_N - 1) begin
        b = good_crc ? acc : (acc ^ 8'($urandom_range(1, 255)));
      end else begin
        b   = 8'($urandom_range(255));
        acc = maxim_crc_byte(acc, b);
      end
      feed(b);
    end
  endfunction

  function automatic logic [31:0] pick_pattern();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom() << (8 * $urandom_range(1, SYNC_N - 1));  // zero low bytes
      default: return $urandom();
    endcase
  endfunction

  // wait until every byte is taken and every message byte has come out
  task automatic settle();
    while (rx_stream.size() != 0 || msg_beats_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_pattern(input logic [31:0] pat);
    @(negedge clk_i);
    cfg_valid   <= 1'b1;
    cfg_pattern <= pat;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    hunt_pattern = pat;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] extremes[MSG_N-1];
    logic [7:0] acc;
    int         phase;

    extremes = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA,
                 8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h01, 8'h80, 8'h3C};
    acc   = '0;
    phase = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Pattern is still zero from reset and the window starts at zero, so one
    // 0x00 byte already completes the sync.
    feed(8'h00);
    // message with field extremes; the pattern is rewritten halfway through
    for (int i = 0; i < 6; i++) begin
      feed(extremes[i]);
    end
    settle();
    write_pattern(32'hAB00_0000);
    for (int i = 6; i < MSG_N - 1; i++) begin
      feed(extremes[i]);
    end
    for (int i = 0; i < MSG_N - 1; i++) begin
      acc = maxim_crc_byte(acc, extremes[i]);
    end
    feed(acc);  // good CRC, old message unaffected by the new pattern
    // zero low bytes in the pattern: a single 0xAB matches right after the end
    feed(8'hAB);
    settle();

    // Random phases: mostly well-formed frames with noise in between, some
    // broken sync runs, bad CRCs and frames cut short across a pattern write.
    while (fed < ITEM_TARGET) begin
      logic [31:0] pat;
      pat = pick_pattern();
      write_pattern(pat);
      calm = (phase >= 2 && phase < 5);
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 4)) feed(8'($urandom_range(255)));
        if ($urandom_range(4) == 0) begin
          feed_sync(pat, $urandom_range(1, SYNC_N - 1));
          feed(8'($urandom_range(255)));
        end
        feed_frame(pat, $urandom_range(9) < 7, MSG_N);
      end
      if ($urandom_range(3) == 0) begin
        feed_frame(pat, 1'b1, $urandom_range(1, MSG_N - 1));
      end
      settle();
      phase++;
    end
    calm = 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
